// File: rtl/cta_pkg.sv
// cube map texel address: shared constants for face codes, config indexes and defaults
// used by the front, back and top level modules; depends on nothing
`default_nettype none

package cta_pkg;

    localparam int DIR_BITS_DEF      = 16;
    localparam int FACE_DIM_BITS_DEF = 12;
    localparam int QUEUE_DEPTH       = 4;

    localparam int FACE_BITS = 3;

    localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FACE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FACE_HEIGHT = 2'd1;

    localparam int DIM_RESET = 512;

endpackage

`default_nettype wire

// File: rtl/cta_front.sv
// cube map texel address front end: major axis pick, face code and division operands
// depends on cta_pkg
`default_nettype none

module cta_front
    import cta_pkg::*;
#(
    parameter int DIR_BITS = DIR_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [DIR_BITS-1:0] i_dir_x,
    input  wire logic signed [DIR_BITS-1:0] i_dir_y,
    input  wire logic signed [DIR_BITS-1:0] i_dir_z,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [FACE_BITS-1:0]            o_face,
    output logic [DIR_BITS:0]               o_num_s,
    output logic [DIR_BITS:0]               o_num_t,
    output logic [DIR_BITS-1:0]             o_ma,
    output logic                            o_zero
);

    function automatic logic [DIR_BITS-1:0] f_abs(input logic [DIR_BITS-1:0] c);
        logic [DIR_BITS:0] ext;
        logic [DIR_BITS:0] neg;
        ext = {c[DIR_BITS-1], c};
        neg = -ext;
        return c[DIR_BITS-1] ? neg[DIR_BITS-1:0] : c;
    endfunction

    // sc + ma (or tc + ma), always in 0 .. 2*ma
    function automatic logic [DIR_BITS:0] f_num(input logic [DIR_BITS-1:0] c,
                                                input logic neg,
                                                input logic [DIR_BITS-1:0] m);
        logic [DIR_BITS+1:0] cs;
        logic [DIR_BITS+1:0] sum;
        cs = {{2{c[DIR_BITS-1]}}, c};
        if (neg) begin
            cs = -cs;
        end
        sum = {2'b00, m} + cs;
        return sum[DIR_BITS:0];
    endfunction

    logic [DIR_BITS-1:0]  ax, ay, az;
    logic                 pos_x, pos_y, pos_z;
    logic [DIR_BITS-1:0]  ma;
    logic [FACE_BITS-1:0] face;
    logic [DIR_BITS-1:0]  sc_c, tc_c;
    logic                 sc_n, tc_n;

    logic                 r_v;
    logic [FACE_BITS-1:0] r_face;
    logic [DIR_BITS:0]    r_num_s, r_num_t;
    logic [DIR_BITS-1:0]  r_ma;
    logic                 r_zero;
    logic                 load;

    assign ax = f_abs(i_dir_x);
    assign ay = f_abs(i_dir_y);
    assign az = f_abs(i_dir_z);

    assign pos_x = !i_dir_x[DIR_BITS-1] && (i_dir_x != '0);
    assign pos_y = !i_dir_y[DIR_BITS-1] && (i_dir_y != '0);
    assign pos_z = !i_dir_z[DIR_BITS-1] && (i_dir_z != '0);

    always_comb begin
        ma   = az;
        face = FACE_NEG_Z;
        sc_c = i_dir_x;
        sc_n = 1'b1;
        tc_c = i_dir_y;
        tc_n = 1'b1;
        priority if (ax > ay && ax > az) begin
            ma   = ax;
            sc_c = i_dir_z;
            tc_c = i_dir_y;
            tc_n = 1'b1;
            if (pos_x) begin
                face = FACE_POS_X;
                sc_n = 1'b1;
            end else begin
                face = FACE_NEG_X;
                sc_n = 1'b0;
            end
        end else if (ay > az) begin
            ma   = ay;
            sc_c = i_dir_x;
            sc_n = 1'b0;
            tc_c = i_dir_z;
            if (pos_y) begin
                face = FACE_POS_Y;
                tc_n = 1'b0;
            end else begin
                face = FACE_NEG_Y;
                tc_n = 1'b1;
            end
        end else begin
            ma   = az;
            sc_c = i_dir_x;
            tc_c = i_dir_y;
            tc_n = 1'b1;
            if (pos_z) begin
                face = FACE_POS_Z;
                sc_n = 1'b0;
            end else begin
                face = FACE_NEG_Z;
                sc_n = 1'b1;
            end
        end
    end

    assign o_ready = !r_v || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_face  <= face;
            r_num_s <= f_num(sc_c, sc_n, ma);
            r_num_t <= f_num(tc_c, tc_n, ma);
            r_ma    <= ma;
            r_zero  <= (ma == '0);
        end
    end

    assign o_valid = r_v;
    assign o_face  = r_face;
    assign o_num_s = r_num_s;
    assign o_num_t = r_num_t;
    assign o_ma    = r_ma;
    assign o_zero  = r_zero;

endmodule

`default_nettype wire

// File: rtl/cta_fifo.sv
// cube map texel address queue between front and back, register based
// no dependencies
`default_nettype none

module cta_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cta_back.sv
// cube map texel address back end: scale, pipelined restoring divide, clamp, linear index
// depends on cta_pkg
`default_nettype none

module cta_back
    import cta_pkg::*;
#(
    parameter int DIR_BITS      = DIR_BITS_DEF,
    parameter int FACE_DIM_BITS = FACE_DIM_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [FACE_DIM_BITS:0]     i_width,
    input  wire logic [FACE_DIM_BITS:0]     i_height,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [FACE_BITS-1:0]       i_face,
    input  wire logic [DIR_BITS:0]          i_num_s,
    input  wire logic [DIR_BITS:0]          i_num_t,
    input  wire logic [DIR_BITS-1:0]        i_ma,
    input  wire logic                       i_zero,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [FACE_BITS-1:0]            o_face,
    output logic [FACE_DIM_BITS-1:0]        o_texel_col,
    output logic [FACE_DIM_BITS-1:0]        o_texel_row,
    output logic [2*FACE_DIM_BITS-1:0]      o_texel_index
);

    localparam int QW = FACE_DIM_BITS + 1;
    localparam int NW = DIR_BITS + FACE_DIM_BITS + 2;
    localparam int RW = DIR_BITS + 1;
    localparam int XW = 2 * FACE_DIM_BITS + 1;

    logic                 en;
    logic [NW-1:0]        prod_s, prod_t;

    logic [QW:0]          r_v;
    logic [RW-1:0]        r_rem_s [0:QW];
    logic [RW-1:0]        r_rem_t [0:QW];
    logic [QW-1:0]        r_low_s [0:QW];
    logic [QW-1:0]        r_low_t [0:QW];
    logic [QW-1:0]        r_q_s   [0:QW];
    logic [QW-1:0]        r_q_t   [0:QW];
    logic [RW-1:0]        r_div   [0:QW];
    logic [FACE_BITS-1:0] r_face  [0:QW];
    logic                 r_zero  [0:QW];

    logic [RW-1:0]        n_rem_s [1:QW];
    logic [RW-1:0]        n_rem_t [1:QW];
    logic [QW-1:0]        n_q_s   [1:QW];
    logic [QW-1:0]        n_q_t   [1:QW];

    logic                 r_vc;
    logic [FACE_BITS-1:0] r_face_c;
    logic [FACE_DIM_BITS-1:0] r_col_c, r_row_c;
    logic [FACE_DIM_BITS-1:0] n_col_c, n_row_c;

    logic                 r_vo;
    logic [FACE_BITS-1:0] r_face_o;
    logic [FACE_DIM_BITS-1:0] r_col_o, r_row_o;
    logic [2*FACE_DIM_BITS-1:0] r_index_o;
    logic [XW-1:0]        lin;

    // whole pipe moves unless the output holds an untaken result
    assign en      = !r_vo || i_ready;
    assign o_ready = en;

    assign prod_s = NW'(i_num_s) * NW'(i_width);
    assign prod_t = NW'(i_num_t) * NW'(i_height);

    // one quotient bit per stage
    always_comb begin
        logic [RW:0] cand_s;
        logic [RW:0] cand_t;
        logic [RW:0] dv;
        for (int k = 1; k <= QW; k++) begin
            dv     = {1'b0, r_div[k-1]};
            cand_s = {r_rem_s[k-1], r_low_s[k-1][QW-1]};
            cand_t = {r_rem_t[k-1], r_low_t[k-1][QW-1]};
            if (cand_s >= dv) begin
                n_rem_s[k] = RW'(cand_s - dv);
                n_q_s[k]   = {r_q_s[k-1][QW-2:0], 1'b1};
            end else begin
                n_rem_s[k] = RW'(cand_s);
                n_q_s[k]   = {r_q_s[k-1][QW-2:0], 1'b0};
            end
            if (cand_t >= dv) begin
                n_rem_t[k] = RW'(cand_t - dv);
                n_q_t[k]   = {r_q_t[k-1][QW-2:0], 1'b1};
            end else begin
                n_rem_t[k] = RW'(cand_t);
                n_q_t[k]   = {r_q_t[k-1][QW-2:0], 1'b0};
            end
        end
    end

    // clamp u or v equal to one, center texel for a zero vector
    always_comb begin
        if (r_zero[QW]) begin
            n_col_c = FACE_DIM_BITS'(i_width >> 1);
            n_row_c = FACE_DIM_BITS'(i_height >> 1);
        end else begin
            n_col_c = (r_q_s[QW] >= i_width)  ? FACE_DIM_BITS'(i_width - 1'b1)
                                              : FACE_DIM_BITS'(r_q_s[QW]);
            n_row_c = (r_q_t[QW] >= i_height) ? FACE_DIM_BITS'(i_height - 1'b1)
                                              : FACE_DIM_BITS'(r_q_t[QW]);
        end
    end

    assign lin = XW'(r_col_c) + XW'(r_row_c) * XW'(i_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_vc <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v  <= {r_v[QW-1:0], i_valid};
            r_vc <= r_v[QW];
            r_vo <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rem_s[0] <= prod_s[NW-1:QW];
            r_rem_t[0] <= prod_t[NW-1:QW];
            r_low_s[0] <= prod_s[QW-1:0];
            r_low_t[0] <= prod_t[QW-1:0];
            r_q_s[0]   <= '0;
            r_q_t[0]   <= '0;
            r_div[0]   <= {i_ma, 1'b0};
            r_face[0]  <= i_face;
            r_zero[0]  <= i_zero;
            for (int k = 1; k <= QW; k++) begin
                r_rem_s[k] <= n_rem_s[k];
                r_rem_t[k] <= n_rem_t[k];
                r_low_s[k] <= {r_low_s[k-1][QW-2:0], 1'b0};
                r_low_t[k] <= {r_low_t[k-1][QW-2:0], 1'b0};
                r_q_s[k]   <= n_q_s[k];
                r_q_t[k]   <= n_q_t[k];
                r_div[k]   <= r_div[k-1];
                r_face[k]  <= r_face[k-1];
                r_zero[k]  <= r_zero[k-1];
            end
            r_face_c  <= r_face[QW];
            r_col_c   <= n_col_c;
            r_row_c   <= n_row_c;
            r_face_o  <= r_face_c;
            r_col_o   <= r_col_c;
            r_row_o   <= r_row_c;
            r_index_o <= lin[2*FACE_DIM_BITS-1:0];
        end
    end

    assign o_valid       = r_vo;
    assign o_face        = r_face_o;
    assign o_texel_col   = r_col_o;
    assign o_texel_row   = r_row_o;
    assign o_texel_index = r_index_o;

endmodule

`default_nettype wire

// File: rtl/cubemap_texel_address_top.sv
// cube map texel address top level: face size registers, front, queue and back
// depends on cta_pkg, cta_front, cta_fifo, cta_back
// throughput one transfer per cycle while i_ready takes results, set by the divider
// pipeline retiring one quotient bit per stage; a four-entry queue decouples
// classification from the divider
// synchronous active-low reset empties the pipe and queue and sets both face sizes to 512
`default_nettype none

module cubemap_texel_address_top
    import cta_pkg::*;
#(
    parameter int DIR_BITS      = DIR_BITS_DEF,
    parameter int FACE_DIM_BITS = FACE_DIM_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [FACE_DIM_BITS:0]     i_cfg_data,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic signed [DIR_BITS-1:0] i_dir_x,
    input  wire logic signed [DIR_BITS-1:0] i_dir_y,
    input  wire logic signed [DIR_BITS-1:0] i_dir_z,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [FACE_BITS-1:0]            o_face,
    output logic [FACE_DIM_BITS-1:0]        o_texel_col,
    output logic [FACE_DIM_BITS-1:0]        o_texel_row,
    output logic [2*FACE_DIM_BITS-1:0]      o_texel_index
);

    localparam int DW  = FACE_DIM_BITS + 1;
    localparam int QDW = FACE_BITS + 2 * (DIR_BITS + 1) + DIR_BITS + 1;
    localparam logic [DW-1:0] DIM_MAX = DW'(1) << FACE_DIM_BITS;

    logic [DW-1:0] r_face_width, r_face_height;
    logic [DW-1:0] eff_w, eff_h;

    logic                 f_valid, f_ready;
    logic [FACE_BITS-1:0] f_face;
    logic [DIR_BITS:0]    f_num_s, f_num_t;
    logic [DIR_BITS-1:0]  f_ma;
    logic                 f_zero;

    logic                 q_valid, q_ready;
    logic [QDW-1:0]       q_in, q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= DW'(DIM_RESET);
            r_face_height <= DW'(DIM_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FACE_WIDTH) begin
                r_face_width <= i_cfg_data;
            end
            if (i_cfg_idx == REG_FACE_HEIGHT) begin
                r_face_height <= i_cfg_data;
            end
        end
    end

    // zero acts as one, oversize acts as the largest face
    always_comb begin
        eff_w = r_face_width;
        eff_h = r_face_height;
        if (r_face_width == '0) begin
            eff_w = DW'(1);
        end else if (r_face_width > DIM_MAX) begin
            eff_w = DIM_MAX;
        end
        if (r_face_height == '0) begin
            eff_h = DW'(1);
        end else if (r_face_height > DIM_MAX) begin
            eff_h = DIM_MAX;
        end
    end

    cta_front #(
        .DIR_BITS (DIR_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_face  (f_face),
        .o_num_s (f_num_s),
        .o_num_t (f_num_t),
        .o_ma    (f_ma),
        .o_zero  (f_zero)
    );

    assign q_in = {f_face, f_num_s, f_num_t, f_ma, f_zero};

    cta_fifo #(
        .WIDTH (QDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (q_in),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_out)
    );

    cta_back #(
        .DIR_BITS      (DIR_BITS),
        .FACE_DIM_BITS (FACE_DIM_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_width       (eff_w),
        .i_height      (eff_h),
        .i_valid       (q_valid),
        .o_ready       (q_ready),
        .i_face        (q_out[QDW-1 -: FACE_BITS]),
        .i_num_s       (q_out[QDW-FACE_BITS-1 -: DIR_BITS+1]),
        .i_num_t       (q_out[DIR_BITS+1+DIR_BITS -: DIR_BITS+1]),
        .i_ma          (q_out[DIR_BITS:1]),
        .i_zero        (q_out[0]),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_face        (o_face),
        .o_texel_col   (o_texel_col),
        .o_texel_row   (o_texel_row),
        .o_texel_index (o_texel_index)
    );

endmodule

`default_nettype wire
